// ----- src/qesp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesp_pkg: shared types and constants of the quadrature encoder decoder
// Field widths, register indexes and reset values, the words that pass
// between the stages, and the count sign extension.
// ----------------------------------------------------------------------------
package qesp_pkg;

   // width of the position counter, 8 to 32
   localparam int CountWidth    = 32;
   localparam int FieldWidth    = 32;
   localparam int RpmWidth      = 47;
   localparam int RevWidth      = 8;
   localparam int ScaleWidth    = 16;
   localparam int MsWidth       = 32;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 1;

   localparam logic [RevWidth-1:0]   RevReset   = RevWidth'(10);
   localparam logic [ScaleWidth-1:0] ScaleReset = ScaleWidth'(375);
   localparam logic [MsWidth-1:0]    MsMax      = {MsWidth{1'b1}};

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_REVOLUTIONS = 1'b0,
      CSR_RPM_SCALE   = 1'b1
   } csr_index_type;

   typedef logic [CountWidth-1:0] count_type;

   // one pin sample as held in the input register
   typedef struct packed {
      logic                         a_level;
      logic                         b_level;
      logic                         index_level;
      logic                         ms_tick;
      logic                         sample_speed;
      logic                         load_count;
      logic signed [FieldWidth-1:0] load_value;
   } req_word_type;

   // decoded word handed from the decode stage to the speed stage
   typedef struct packed {
      logic signed [FieldWidth-1:0] position_count;
      logic                         direction;
      logic signed [FieldWidth-1:0] speed_delta;
      logic [FieldWidth-1:0]        delta_magnitude;
      logic                         speed_strobe;
      logic [MsWidth-1:0]           interval_total_ms;
      logic                         interval_new;
      logic                         edge_error;
   } mid_word_type;

   // result word as held in the output register
   typedef struct packed {
      logic signed [FieldWidth-1:0] position_count;
      logic                         direction;
      logic signed [FieldWidth-1:0] speed_delta;
      logic [RpmWidth-1:0]          rpm_x64;
      logic [MsWidth-1:0]           interval_total_ms;
      logic                         interval_new;
      logic                         edge_error;
   } rsp_word_type;

   function automatic logic signed [FieldWidth-1:0] sign_extend_count(input count_type v);
      return FieldWidth'(signed'(v));
   endfunction

endpackage

// ----- src/qesp_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesp_req_if: pin sample channel
// Valid/ready channel that carries one sample of the encoder pins per word.
// ----------------------------------------------------------------------------
interface qesp_req_if
   import qesp_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic                         a_level;
   logic                         b_level;
   logic                         index_level;
   logic                         ms_tick;
   logic                         sample_speed;
   logic                         load_count;
   logic signed [FieldWidth-1:0] load_value;

   modport source (
      output valid, a_level, b_level, index_level, ms_tick, sample_speed,
             load_count, load_value,
      input  ready
   );

   modport sink (
      input  valid, a_level, b_level, index_level, ms_tick, sample_speed,
             load_count, load_value,
      output ready
   );
endinterface

// ----- src/qesp_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesp_rsp_if: result channel
// Valid/ready channel that carries one decoder result word per sample.
// ----------------------------------------------------------------------------
interface qesp_rsp_if
   import qesp_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic signed [FieldWidth-1:0] position_count;
   logic                         direction;
   logic signed [FieldWidth-1:0] speed_delta;
   logic [RpmWidth-1:0]          rpm_x64;
   logic [MsWidth-1:0]           interval_total_ms;
   logic                         interval_new;
   logic                         edge_error;

   modport source (
      output valid, position_count, direction, speed_delta, rpm_x64,
             interval_total_ms, interval_new, edge_error,
      input  ready
   );

   modport sink (
      input  valid, position_count, direction, speed_delta, rpm_x64,
             interval_total_ms, interval_new, edge_error,
      output ready
   );
endinterface

// ----- src/qesp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesp_decode: input register and x4 decode stage
// Registers each pin sample, then updates position, speed snapshot,
// millisecond total and revolution count in one pass and hands the
// decoded word to the speed stage.
// ----------------------------------------------------------------------------
module qesp_decode
   import qesp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   qesp_req_if.sink           req_chan,
   input  logic [RevWidth-1:0] revolutions_to_average,
   output mid_word_type       mid_word,
   output logic               mid_valid,
   input  logic               mid_ready,
   output logic               in_busy
);

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         in_ready;
   logic         advance;

   logic                  prev_a_ff, prev_a_in;
   logic                  prev_b_ff, prev_b_in;
   logic                  prev_index_ff, prev_index_in;
   count_type             position_ff, position_in;
   count_type             snapshot_ff, snapshot_in;
   logic                  direction_ff, direction_in;
   logic signed [FieldWidth-1:0] delta_ff, delta_in;
   logic [RevWidth-1:0]   rev_count_ff, rev_count_in;
   logic [MsWidth-1:0]    running_ms_ff, running_ms_in;
   logic [MsWidth-1:0]    interval_ff, interval_in;

   mid_word_type mid_word_ff, mid_word_in;
   logic         mid_valid_ff, mid_valid_in;

   logic                  a_changed, b_changed, phase_xor;
   count_type             pos_decoded;
   logic                  dir_decoded;
   logic                  edge_error;
   logic signed [FieldWidth-1:0] delta_now;
   logic [FieldWidth-1:0] delta_mag;
   logic [MsWidth-1:0]    ms_ticked;
   logic [RevWidth-1:0]   rev_next;
   logic                  interval_new;

   // input register: take a word whenever it is empty or drains this cycle
   assign in_ready       = !in_valid_ff || mid_ready;
   assign req_chan.ready = in_ready;
   assign advance        = in_valid_ff && mid_ready;
   assign in_valid_in    = in_ready ? req_chan.valid : in_valid_ff;

   // phase decode by the xor rule; both phases moving holds the count
   always_comb begin
      a_changed   = in_word_ff.a_level ^ prev_a_ff;
      b_changed   = in_word_ff.b_level ^ prev_b_ff;
      phase_xor   = in_word_ff.a_level ^ in_word_ff.b_level;
      pos_decoded = position_ff;
      dir_decoded = direction_ff;
      edge_error  = 1'b0;
      priority if (a_changed && b_changed) begin
         edge_error = 1'b1;
      end else if (a_changed || b_changed) begin
         // forward when the changed phase agrees with the xor rule
         dir_decoded = ~(phase_xor ^ b_changed);
         pos_decoded = dir_decoded ? position_ff - count_type'(1)
                                   : position_ff + count_type'(1);
      end else begin
         edge_error = 1'b0;
      end
   end

   // preset, speed strobe, millisecond count and index edge
   always_comb begin
      position_in = in_word_ff.load_count ? in_word_ff.load_value[CountWidth-1:0]
                                          : pos_decoded;
      delta_now   = sign_extend_count(position_in - snapshot_ff);
      delta_mag   = delta_now[FieldWidth-1] ? FieldWidth'(0) - FieldWidth'(delta_now)
                                            : FieldWidth'(delta_now);
      snapshot_in = in_word_ff.sample_speed ? position_in : snapshot_ff;
      delta_in    = in_word_ff.sample_speed ? delta_now : delta_ff;

      ms_ticked = (in_word_ff.ms_tick && running_ms_ff != MsMax)
                  ? running_ms_ff + MsWidth'(1) : running_ms_ff;
      rev_next      = rev_count_ff + RevWidth'(1);
      running_ms_in = ms_ticked;
      rev_count_in  = rev_count_ff;
      interval_in   = interval_ff;
      interval_new  = 1'b0;
      if (in_word_ff.index_level && !prev_index_ff) begin
         rev_count_in = rev_next;
         if (rev_next == revolutions_to_average) begin
            interval_in   = ms_ticked;
            running_ms_in = '0;
            rev_count_in  = '0;
            interval_new  = 1'b1;
         end
      end

      prev_a_in     = in_word_ff.a_level;
      prev_b_in     = in_word_ff.b_level;
      prev_index_in = in_word_ff.index_level;
      direction_in  = dir_decoded;
   end

   // decoded word for the speed stage
   always_comb begin
      mid_word_in.position_count    = sign_extend_count(position_in);
      mid_word_in.direction         = dir_decoded;
      mid_word_in.speed_delta       = delta_in;
      mid_word_in.delta_magnitude   = delta_mag;
      mid_word_in.speed_strobe      = in_word_ff.sample_speed;
      mid_word_in.interval_total_ms = interval_in;
      mid_word_in.interval_new      = interval_new;
      mid_word_in.edge_error        = edge_error;
      mid_valid_in = mid_ready ? in_valid_ff : mid_valid_ff;
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mid_valid_ff  <= 1'b0;
         prev_a_ff     <= 1'b0;
         prev_b_ff     <= 1'b0;
         prev_index_ff <= 1'b0;
         position_ff   <= '0;
         snapshot_ff   <= '0;
         direction_ff  <= 1'b0;
         delta_ff      <= '0;
         rev_count_ff  <= '0;
         running_ms_ff <= '0;
         interval_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         if (advance) begin
            prev_a_ff     <= prev_a_in;
            prev_b_ff     <= prev_b_in;
            prev_index_ff <= prev_index_in;
            position_ff   <= position_in;
            snapshot_ff   <= snapshot_in;
            direction_ff  <= direction_in;
            delta_ff      <= delta_in;
            rev_count_ff  <= rev_count_in;
            running_ms_ff <= running_ms_in;
            interval_ff   <= interval_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_word_ff.a_level      <= req_chan.a_level;
         in_word_ff.b_level      <= req_chan.b_level;
         in_word_ff.index_level  <= req_chan.index_level;
         in_word_ff.ms_tick      <= req_chan.ms_tick;
         in_word_ff.sample_speed <= req_chan.sample_speed;
         in_word_ff.load_count   <= req_chan.load_count;
         in_word_ff.load_value   <= req_chan.load_value;
      end
      if (advance) begin
         mid_word_ff <= mid_word_in;
      end
   end

   assign mid_word  = mid_word_ff;
   assign mid_valid = mid_valid_ff;
   assign in_busy   = in_valid_ff;

endmodule

// ----- src/qesp_speed.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qesp_speed: rpm multiply and output register
// Scales the latched delta magnitude on a speed strobe, holds the latched
// rpm between strobes and registers the result word.
// ----------------------------------------------------------------------------
module qesp_speed
   import qesp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  mid_word_type          mid_word,
   input  logic                  mid_valid,
   output logic                  mid_ready,
   input  logic [ScaleWidth-1:0] rpm_scale,
   qesp_rsp_if.source            rsp_chan
);

   logic                 out_valid_ff, out_valid_in;
   rsp_word_type         out_word_ff, out_word_in;
   logic [RpmWidth-1:0]  rpm_ff, rpm_in;
   logic [FieldWidth+ScaleWidth-1:0] product;
   logic                 take;

   // output register frees when empty or when its word is taken
   assign mid_ready    = !out_valid_ff || rsp_chan.ready;
   assign take         = mid_valid && mid_ready;
   assign out_valid_in = mid_ready ? mid_valid : out_valid_ff;

   // scale the magnitude, 32 by 16 bits
   assign product = (FieldWidth+ScaleWidth)'(mid_word.delta_magnitude) *
                    (FieldWidth+ScaleWidth)'(rpm_scale);
   assign rpm_in  = mid_word.speed_strobe ? product[RpmWidth-1:0] : rpm_ff;

   always_comb begin
      out_word_in.position_count    = mid_word.position_count;
      out_word_in.direction         = mid_word.direction;
      out_word_in.speed_delta       = mid_word.speed_delta;
      out_word_in.rpm_x64           = rpm_in;
      out_word_in.interval_total_ms = mid_word.interval_total_ms;
      out_word_in.interval_new      = mid_word.interval_new;
      out_word_in.edge_error        = mid_word.edge_error;
   end

   // control and latched rpm
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         rpm_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            rpm_ff <= rpm_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.position_count    = out_word_ff.position_count;
   assign rsp_chan.direction         = out_word_ff.direction;
   assign rsp_chan.speed_delta       = out_word_ff.speed_delta;
   assign rsp_chan.rpm_x64           = out_word_ff.rpm_x64;
   assign rsp_chan.interval_total_ms = out_word_ff.interval_total_ms;
   assign rsp_chan.interval_new      = out_word_ff.interval_new;
   assign rsp_chan.edge_error        = out_word_ff.edge_error;

endmodule

// ----- src/quadrature_encoder_speed_period.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_speed_period: x4 quadrature decoder with speed and
// revolution period measurement
// Top level: configuration registers, decode stage and speed stage.
// ----------------------------------------------------------------------------
// The block takes one pin sample word per clock unless stalled and returns
// one result word per sample, in order: a word passes the input register,
// the decode stage register and then the output register. Throughput is one
// word per cycle while the result side does not stall, set by the position
// and revolution state update in the decode stage; the rpm multiply (32 by
// 16 bits) has its own stage. A stall on the result side freezes the decode
// and output registers together, so an empty slot between words is not
// closed up; the sample side sees ready low while the input register holds
// a word and the decode stage is stalled. The user must write configuration
// through the csr port while no words are in flight; the block does not enforce it.
module quadrature_encoder_speed_period
   import qesp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   qesp_req_if.sink                 req_chan,
   qesp_rsp_if.source               rsp_chan,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   logic [RevWidth-1:0]   rev_avg_ff, rev_avg_in;
   logic [ScaleWidth-1:0] scale_ff, scale_in;
   mid_word_type          mid_word;
   logic                  mid_valid;
   logic                  mid_ready;
   logic                  in_busy;

   // register write decode
   always_comb begin
      rev_avg_in = rev_avg_ff;
      scale_in   = scale_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REVOLUTIONS: rev_avg_in = csr_write_data[RevWidth-1:0];
            CSR_RPM_SCALE:   scale_in   = csr_write_data[ScaleWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_avg_ff <= RevReset;
         scale_ff   <= ScaleReset;
      end else begin
         rev_avg_ff <= rev_avg_in;
         scale_ff   <= scale_in;
      end
   end

   qesp_decode u_decode (
      .clock                  (clock),
      .reset                  (reset),
      .req_chan               (req_chan),
      .revolutions_to_average (rev_avg_ff),
      .mid_word               (mid_word),
      .mid_valid              (mid_valid),
      .mid_ready              (mid_ready),
      .in_busy                (in_busy)
   );

   qesp_speed u_speed (
      .clock     (clock),
      .reset     (reset),
      .mid_word  (mid_word),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .rpm_scale (scale_ff),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   logic [1:0] in_flight;
   logic       req_fire;
   logic       rsp_fire;
   assign in_flight = 2'(in_busy) + 2'(mid_valid) + 2'(rsp_chan.valid);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;

   // a word taken in and none delivered grows the occupancy by one
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_fire && !rsp_fire |=> in_flight == $past(in_flight) + 2'd1)
      else $error("occupancy did not grow on accept");

   // a word delivered and none taken in shrinks the occupancy by one
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !req_fire && rsp_fire |=> in_flight == $past(in_flight) - 2'd1)
      else $error("occupancy did not shrink on delivery");

   // a nonzero speed always comes from a nonzero latched delta
   a_rpm: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.rpm_x64 != '0 |-> rsp_chan.speed_delta != '0)
      else $error("rpm without a latched delta");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the x4 quadrature decoder
// Sends pin sample words over the request channel, predicts every result
// word from a cycle-free model of the decoder, the speed strobe and the
// index period logic, and compares each result word field by field.
// Directed words cover the decode rule, presets, wraps and strobes; random
// phases walk the phases mostly in gray order with random content, under several
// register settings, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import qesp_pkg::*;

   localparam int LatencyCycles = 3;
   localparam int HoldOffCycles = 200;
   localparam int WatchdogLimit = 4000;

   typedef enum int {
      RX_STEADY,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   logic clock;
   logic reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   qesp_req_if req_chan ();
   qesp_rsp_if rsp_chan ();

   quadrature_encoder_speed_period dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // decoder state as predicted
   logic                  last_a;
   logic                  last_b;
   logic                  last_index;
   count_type             count_now;
   count_type             count_at_strobe;
   logic                  dir_now;
   logic [FieldWidth-1:0] held_delta;
   logic [RpmWidth-1:0]   held_rpm;
   logic [RevWidth-1:0]   revs_seen;
   logic [MsWidth-1:0]    ms_running;
   logic [MsWidth-1:0]    ms_latched;
   logic [RevWidth-1:0]   set_revs;
   logic [ScaleWidth-1:0] set_scale;
   int                    interval_latches;

   rsp_word_type expected_results[$];
   rsp_word_type want_word;
   int           fail_count;
   int           quiet_cycles;
   int           burst_left;
   logic         spin_reverse;
   logic         hold_off_request;

   rx_mode_type rx_mode;
   int          rx_left;
   int          rx_period;
   int          rx_tick;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // prediction
   // -------------------------------------------------------------------------
   function automatic void reset_predictor();
      last_a           = 1'b0;
      last_b           = 1'b0;
      last_index       = 1'b0;
      count_now        = '0;
      count_at_strobe  = '0;
      dir_now          = 1'b0;
      held_delta       = '0;
      held_rpm         = '0;
      revs_seen        = '0;
      ms_running       = '0;
      ms_latched       = '0;
      set_revs         = RevReset;
      set_scale        = ScaleReset;
      interval_latches = 0;
   endfunction

   // advance the decoder by one sample word and return its result word
   function automatic rsp_word_type predict_result(input req_word_type word);
      logic                         a_move;
      logic                         b_move;
      logic                         phase_x;
      count_type                    diff;
      logic signed [FieldWidth-1:0] diff_ext;
      logic signed [FieldWidth-1:0] count_ext;
      logic [FieldWidth-1:0]        magnitude;
      logic [63:0]                  product;
      rsp_word_type                 result;
      a_move  = word.a_level ^ last_a;
      b_move  = word.b_level ^ last_b;
      phase_x = word.a_level ^ word.b_level;
      result  = '0;

      // decode: both phases moving is an error and holds the count
      if (a_move && b_move) begin
         result.edge_error = 1'b1;
      end else if (a_move) begin
         count_now = phase_x ? count_now + 1'b1 : count_now - 1'b1;
         dir_now   = ~phase_x;
      end else if (b_move) begin
         count_now = phase_x ? count_now - 1'b1 : count_now + 1'b1;
         dir_now   = phase_x;
      end
      last_a = word.a_level;
      last_b = word.b_level;

      // preset overrides any count decoded in the same word
      if (word.load_count) begin
         count_now = word.load_value[CountWidth-1:0];
      end

      // speed strobe: latch delta since last strobe and scaled magnitude
      if (word.sample_speed) begin
         diff            = count_now - count_at_strobe;
         diff_ext        = $signed(diff);
         magnitude       = diff_ext[FieldWidth-1] ? -diff_ext : diff_ext;
         product         = 64'(magnitude) * 64'(set_scale);
         held_delta      = diff_ext;
         held_rpm        = product[RpmWidth-1:0];
         count_at_strobe = count_now;
      end

      // count the tick before a possible interval latch
      if (word.ms_tick && ms_running != MsMax) begin
         ms_running = ms_running + 1'b1;
      end

      if (word.index_level && !last_index) begin
         revs_seen = revs_seen + 1'b1;
         if (revs_seen == set_revs) begin
            ms_latched          = ms_running;
            ms_running          = '0;
            revs_seen           = '0;
            result.interval_new = 1'b1;
            interval_latches++;
         end
      end
      last_index = word.index_level;

      count_ext                = $signed(count_now);
      result.position_count    = count_ext;
      result.direction         = dir_now;
      result.speed_delta       = held_delta;
      result.rpm_x64           = held_rpm;
      result.interval_total_ms = ms_latched;
      return result;
   endfunction

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   function automatic req_word_type sample_word(input logic a, input logic b,
         input logic index, input logic tick, input logic strobe, input logic load,
         input logic [FieldWidth-1:0] preset);
      req_word_type word;
      word.a_level      = a;
      word.b_level      = b;
      word.index_level  = index;
      word.ms_tick      = tick;
      word.sample_speed = strobe;
      word.load_count   = load;
      word.load_value   = preset;
      return word;
   endfunction

   // mostly gray steps in a drifting direction, plus holds, errors and noise
   function automatic req_word_type random_sample(input bit dense_index);
      req_word_type word;
      int           pick;
      pick = $urandom_range(0, 99);
      word = sample_word(last_a, last_b, last_index, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 7) == 0, $urandom_range(0, 31) == 0,
                         $urandom);
      if ($urandom_range(0, 15) == 0) begin
         spin_reverse = ~spin_reverse;
      end
      if (pick < 70) begin
         if ((last_a == last_b) ^ spin_reverse) begin
            word.a_level = ~last_a;
         end else begin
            word.b_level = ~last_b;
         end
      end else if (pick < 80) begin
         word.a_level = ~last_a;
         word.b_level = ~last_b;
      end else if (pick >= 90) begin
         word.a_level = 1'($urandom_range(0, 1));
         word.b_level = 1'($urandom_range(0, 1));
      end
      if (dense_index || $urandom_range(0, 3) == 0) begin
         word.index_level = ~last_index;
      end
      case ($urandom_range(0, 15))
         0: word.load_value = 32'h8000_0000;
         1: word.load_value = 32'h7FFF_FFFF;
         2: word.load_value = '0;
         3: word.load_value = '1;
         default: ;
      endcase
      return word;
   endfunction

   // offer one word and hold it until accepted
   task automatic send_word(input req_word_type word);
      req_chan.valid        <= 1'b1;
      req_chan.a_level      <= word.a_level;
      req_chan.b_level      <= word.b_level;
      req_chan.index_level  <= word.index_level;
      req_chan.ms_tick      <= word.ms_tick;
      req_chan.sample_speed <= word.sample_speed;
      req_chan.load_count   <= word.load_count;
      req_chan.load_value   <= word.load_value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_results.push_back(predict_result(word));
   endtask

   task automatic idle_for(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // send one random word, opening a new burst, mostly after a random gap
   task automatic send_random_sample(input bit dense_index);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 3) != 0) begin
            idle_for($urandom_range(1, 10));
         end
      end
      burst_left--;
      send_word(random_sample(dense_index));
   endtask

   // stop sending and wait for every result word, then for the pipeline
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 2) @(posedge clock);
   endtask

   task automatic write_settings(input logic [RevWidth-1:0] revs,
         input logic [ScaleWidth-1:0] scale);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_REVOLUTIONS;
      csr_write_data   <= CsrDataWidth'(revs);
      @(posedge clock);
      set_revs         = revs;
      csr_index        <= CSR_RPM_SCALE;
      csr_write_data   <= scale;
      @(posedge clock);
      set_scale        = scale;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   // decode rule both ways, error, preset over edge, wraps and strobes
   task automatic test_decode_directed();
      send_word(sample_word(1, 0, 0, 0, 0, 0, '0));
      send_word(sample_word(1, 1, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 1, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 0, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 1, 0, 0, 0, 0, '0));
      send_word(sample_word(1, 1, 0, 0, 0, 0, '0));
      send_word(sample_word(1, 0, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 1, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 1, 0, 1, 0, 0, '0));
      send_word(sample_word(1, 1, 0, 0, 1, 1, 32'h7FFF_FFFF));
      send_word(sample_word(1, 0, 0, 0, 1, 0, '0));
      send_word(sample_word(1, 1, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 1, 0, 0, 1, 0, '0));
      send_word(sample_word(0, 1, 0, 0, 1, 1, 32'hFFFF_FFFF));
      send_word(sample_word(0, 0, 0, 0, 1, 0, '0));
      send_word(sample_word(0, 0, 0, 0, 1, 1, 32'h8000_0000));
      send_word(sample_word(0, 0, 1, 1, 1, 1, '0));
      drain_results();
   endtask

   // latch on every index edge, tick counted first; largest rpm product
   task automatic test_index_and_scale();
      write_settings(8'd1, 16'hFFFF);
      send_word(sample_word(0, 0, 0, 1, 0, 0, '0));
      send_word(sample_word(0, 0, 1, 1, 0, 0, '0));
      send_word(sample_word(0, 0, 0, 0, 0, 0, '0));
      send_word(sample_word(0, 0, 1, 0, 0, 0, '0));
      send_word(sample_word(0, 0, 0, 0, 1, 1, 32'h8000_0000));
      send_word(sample_word(0, 0, 0, 0, 1, 1, 32'h7FFF_FFFF));
      drain_results();
   endtask

   task automatic test_random_phase(input logic [RevWidth-1:0] revs,
         input logic [ScaleWidth-1:0] scale, input int words);
      write_settings(revs, scale);
      repeat (words) send_random_sample(1'b0);
      drain_results();
   endtask

   // stall the result side for a long stretch while words keep coming
   task automatic test_backpressure();
      write_settings(8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)));
      hold_off_request = 1'b1;
      repeat (40) send_word(random_sample(1'b0));
      drain_results();
   endtask

   // a zero setting below the running count latches only after the wrap
   task automatic test_revolution_wrap();
      int start_latches;
      int sent;
      write_settings(8'd3, 16'($urandom_range(0, 65535)));
      start_latches = interval_latches;
      sent = 0;
      while (!(interval_latches > start_latches && revs_seen == 8'd2) && sent < 200) begin
         send_random_sample(1'b1);
         sent++;
      end
      drain_results();
      write_settings(8'd0, 16'($urandom_range(0, 65535)));
      start_latches = interval_latches;
      sent = 0;
      while (interval_latches == start_latches && sent < 1200) begin
         send_random_sample(1'b1);
         sent++;
      end
      repeat (20) send_random_sample(1'b1);
      drain_results();
   endtask

   initial begin
      reset_predictor();
      fail_count       = 0;
      burst_left       = 0;
      spin_reverse     = 1'b0;
      hold_off_request = 1'b0;
      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_REVOLUTIONS;
      csr_write_data        <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.a_level      <= 1'b0;
      req_chan.b_level      <= 1'b0;
      req_chan.index_level  <= 1'b0;
      req_chan.ms_tick      <= 1'b0;
      req_chan.sample_speed <= 1'b0;
      req_chan.load_count   <= 1'b0;
      req_chan.load_value   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_decode_directed();
      test_index_and_scale();
      test_random_phase(8'd1, 16'hFFFF, 120);
      test_random_phase(8'd255, 16'h0000, 100);
      test_random_phase(8'($urandom_range(2, 254)), 16'($urandom_range(0, 65535)), 80);
      test_backpressure();
      test_revolution_wrap();

      drain_results();
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // result side: stall patterns and long hold-off
   // -------------------------------------------------------------------------
   initial begin
      rsp_chan.ready <= 1'b0;
      rx_left   = 0;
      rx_tick   = 0;
      rx_period = 2;
      rx_mode   = RX_STEADY;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            if (rx_left == 0) begin
               rx_left   = $urandom_range(8, 96);
               rx_period = $urandom_range(2, 5);
               case ($urandom_range(0, 2))
                  0: rx_mode = RX_STEADY;
                  1: rx_mode = RX_RANDOM;
                  default: rx_mode = RX_PERIODIC;
               endcase
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
               RX_STEADY:   rsp_chan.ready <= 1'b1;
               RX_RANDOM:   rsp_chan.ready <= $urandom_range(0, 3) != 0;
               RX_PERIODIC: rsp_chan.ready <= (rx_tick % rx_period) != 0;
               default:     rsp_chan.ready <= 1'b1;
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [63:0] want,
         input logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
   endtask

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result word with no expectation pending", $time);
            fail_count++;
         end else begin
            want_word = expected_results.pop_front();
            if (rsp_chan.position_count !== want_word.position_count)
               report_mismatch("position_count", 64'(want_word.position_count),
                               64'(rsp_chan.position_count));
            if (rsp_chan.direction !== want_word.direction)
               report_mismatch("direction", 64'(want_word.direction),
                               64'(rsp_chan.direction));
            if (rsp_chan.speed_delta !== want_word.speed_delta)
               report_mismatch("speed_delta", 64'(want_word.speed_delta),
                               64'(rsp_chan.speed_delta));
            if (rsp_chan.rpm_x64 !== want_word.rpm_x64)
               report_mismatch("rpm_x64", 64'(want_word.rpm_x64), 64'(rsp_chan.rpm_x64));
            if (rsp_chan.interval_total_ms !== want_word.interval_total_ms)
               report_mismatch("interval_total_ms", 64'(want_word.interval_total_ms),
                               64'(rsp_chan.interval_total_ms));
            if (rsp_chan.interval_new !== want_word.interval_new)
               report_mismatch("interval_new", 64'(want_word.interval_new),
                               64'(rsp_chan.interval_new));
            if (rsp_chan.edge_error !== want_word.edge_error)
               report_mismatch("edge_error", 64'(want_word.edge_error),
                               64'(rsp_chan.edge_error));
         end
      end
   end

   // end the run when no word moves on either channel for too long
   initial quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WatchdogLimit) begin
         $display("%0t: no word accepted for %0d cycles", $time, WatchdogLimit);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
src/qesp_pkg.sv
src/qesp_req_if.sv
src/qesp_rsp_if.sv
src/qesp_decode.sv
src/qesp_speed.sv
src/quadrature_encoder_speed_period.sv
tb/testbench.sv
